// ----- hw/rtl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked property checks used by the RTL; all expect clk and arst_n in scope.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge outside reset.
`define SSA_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Check that a condition implies another in the next cycle.
`define SSA_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- hw/rtl/ssa_pkg.sv -----
// ----------------------------------------------------------------------------
// Sorted shift array package
// Operation and status codes and the cell control and flag structs.
// ----------------------------------------------------------------------------
package ssa_pkg;

	typedef enum logic [1:0] {
		OP_INSERT = 2'd0,
		OP_DELETE = 2'd1,
		OP_SORTED = 2'd2,
		OP_REMOVE = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_FULL      = 2'd1,
		ST_BAD_POS   = 2'd2,
		ST_NOT_FOUND = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		CELL_HOLD  = 2'd0,
		CELL_LOAD  = 2'd1,
		CELL_LEFT  = 2'd2,
		CELL_RIGHT = 2'd3
	} cell_cmd_t;

	typedef struct packed {
		cell_cmd_t cmd;
	} cell_ctrl_t;

	typedef struct packed {
		logic le;
		logic eq;
	} cell_flag_t;

	localparam int DataW = 32;

endpackage

// ----- hw/rtl/ssa_cell.sv -----
// ----------------------------------------------------------------------------
// Sorted shift array cell
// Holds one entry, compares it against the search key and takes a new
// value from the request or from either neighbor.
// ----------------------------------------------------------------------------
module ssa_cell import ssa_pkg::*; (
	input  logic                    clk,
	input  logic signed [DataW-1:0] key,
	input  logic signed [DataW-1:0] ins_value,
	input  logic signed [DataW-1:0] left_data,
	input  logic signed [DataW-1:0] right_data,
	input  cell_ctrl_t              ctrl,
	output logic signed [DataW-1:0] data,
	output cell_flag_t              flags
);

	logic signed [DataW-1:0] entry_q;

	// Entry content has no reset; only entries below the fill count are used.
	always_ff @(posedge clk) begin
		unique case (ctrl.cmd)
			CELL_LOAD:  entry_q <= ins_value;
			CELL_LEFT:  entry_q <= left_data;
			CELL_RIGHT: entry_q <= right_data;
			default:    entry_q <= entry_q;
		endcase
	end

	assign data     = entry_q;
	assign flags.le = (entry_q <= key);
	assign flags.eq = (entry_q == key);

endmodule

// ----- hw/rtl/sorted_shift_array_unit.sv -----
// Flow: a request passes the compare, resolve and shift steps and then the result register;
// one request is in flight at a time, and the next is taken as the last result is registered;
// a stalled result holds the request in the last stage and the input with it.
// Reset: fill count cleared, capacity set to 16, cell contents left undefined.
// ----------------------------------------------------------------------------
// Sorted shift array unit
// Row of entry cells with positional insert/delete, sorted add and remove by value.
// ----------------------------------------------------------------------------
module sorted_shift_array_unit import ssa_pkg::*; #(
	parameter int DEPTH = 16
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    cfg_we,
	input  logic [4:0]              cfg_wdata,
	input  logic                    req_valid,
	output logic                    req_stall,
	input  logic [1:0]              op,
	input  logic [4:0]              position,
	input  logic signed [DataW-1:0] value,
	output logic                    res_valid,
	input  logic                    res_stall,
	output logic                    ok,
	output logic [1:0]              status,
	output logic [3:0]              where,
	output logic [4:0]              count,
	output logic                    full_res
);

	`include "assert_macros.svh"

	localparam int IW   = $clog2(DEPTH);
	localparam int UW   = $clog2(DEPTH + 1);
	localparam int CMPW = ((UW > 5) ? UW : 5) + 1;

	logic [4:0]    capacity_q;
	logic [UW-1:0] used_q;
	logic          busy_q;

	logic                    valid_s1, valid_s2, valid_s3;
	op_t                     op_s1, op_s2, op_s3;
	logic [4:0]              pos_s1, pos_s2;
	logic signed [DataW-1:0] val_s1, val_s2, val_s3;
	logic [DEPTH-1:0]        le_s2, eq_s2;
	logic                    ok_s3;
	status_t                 status_s3;
	logic [IW-1:0]           at_s3;

	logic       res_valid_q, ok_q, full_q;
	status_t    status_q;
	logic [3:0] where_q;
	logic [4:0] count_q;

	logic                    accept, fire, ins_kind_s3, ins_fire;
	logic [CMPW-1:0]         cap_eff;
	logic [UW-1:0]           used_next;
	cell_ctrl_t              cell_ctrl  [DEPTH];
	cell_flag_t              cell_flags [DEPTH];
	logic signed [DataW-1:0] cell_data  [DEPTH];

	assign accept      = req_valid && !req_stall;
	assign fire        = valid_s3 && (!res_valid_q || !res_stall);
	assign req_stall   = busy_q && !fire;
	assign ins_kind_s3 = (op_s3 == OP_INSERT) || (op_s3 == OP_SORTED);
	assign ins_fire    = fire && ok_s3 && ins_kind_s3;

	always_comb begin
		logic [CMPW-1:0] cap_x;
		logic [CMPW-1:0] depth_x;
		cap_x   = CMPW'(capacity_q);
		depth_x = CMPW'(DEPTH);
		cap_eff = (cap_x > depth_x) ? depth_x : cap_x;
	end

	// Cell row
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic signed [DataW-1:0] left_d, right_d;

		if (i == 0) begin : g_first
			assign left_d = val_s3;
		end else begin : g_mid_l
			assign left_d = cell_data[i-1];
		end
		if (i == DEPTH - 1) begin : g_last
			assign right_d = cell_data[i];
		end else begin : g_mid_r
			assign right_d = cell_data[i+1];
		end

		always_comb begin
			cell_ctrl[i].cmd = CELL_HOLD;
			if (fire && ok_s3) begin
				if (ins_kind_s3) begin
					if (IW'(i) == at_s3) begin
						cell_ctrl[i].cmd = CELL_LOAD;
					end else if (UW'(i) > UW'(at_s3) && UW'(i) <= used_q) begin
						cell_ctrl[i].cmd = CELL_LEFT;
					end
				end else if (UW'(i) >= UW'(at_s3) && UW'(i + 1) < used_q) begin
					cell_ctrl[i].cmd = CELL_RIGHT;
				end
			end
		end

		ssa_cell u_cell (
			.clk        (clk),
			.key        (val_s1),
			.ins_value  (val_s3),
			.left_data  (left_d),
			.right_data (right_d),
			.ctrl       (cell_ctrl[i]),
			.data       (cell_data[i]),
			.flags      (cell_flags[i])
		);
	end

	// Resolve step: status and target index from the registered match masks
	logic          ok_d;
	status_t       status_d;
	logic [IW-1:0] at_d;

	always_comb begin
		logic          le_any, eq_any, full;
		logic [IW-1:0] le_top, eq_low;
		le_any = 1'b0;
		eq_any = 1'b0;
		le_top = '0;
		eq_low = '0;
		full   = CMPW'(used_q) >= cap_eff;
		for (int i = 0; i < DEPTH; i++) begin
			if (le_s2[i]) begin
				le_any = 1'b1;
				le_top = IW'(i);
			end
		end
		for (int i = DEPTH - 1; i >= 0; i--) begin
			if (eq_s2[i]) begin
				eq_any = 1'b1;
				eq_low = IW'(i);
			end
		end
		ok_d     = 1'b0;
		status_d = ST_OK;
		at_d     = '0;
		unique case (op_s2)
			OP_INSERT: begin
				if (full) begin
					status_d = ST_FULL;
				end else if (CMPW'(pos_s2) > CMPW'(used_q)) begin
					status_d = ST_BAD_POS;
				end else begin
					ok_d = 1'b1;
					at_d = IW'(pos_s2);
				end
			end
			OP_DELETE: begin
				if (CMPW'(pos_s2) >= CMPW'(used_q)) begin
					status_d = ST_BAD_POS;
				end else begin
					ok_d = 1'b1;
					at_d = IW'(pos_s2);
				end
			end
			OP_SORTED: begin
				if (full) begin
					status_d = ST_FULL;
				end else begin
					ok_d = 1'b1;
					at_d = le_any ? IW'(le_top + 1'b1) : '0;
				end
			end
			default: begin
				if (!eq_any) begin
					status_d = ST_NOT_FOUND;
				end else begin
					ok_d = 1'b1;
					at_d = eq_low;
				end
			end
		endcase
	end

	always_comb begin
		used_next = used_q;
		if (fire && ok_s3) begin
			used_next = ins_kind_s3 ? used_q + 1'b1 : used_q - 1'b1;
		end
	end

	// Payload stages
	always_ff @(posedge clk) begin
		if (accept) begin
			op_s1  <= op_t'(op);
			pos_s1 <= position;
			val_s1 <= value;
		end
		if (valid_s1) begin
			op_s2  <= op_s1;
			pos_s2 <= pos_s1;
			val_s2 <= val_s1;
			for (int i = 0; i < DEPTH; i++) begin
				le_s2[i] <= cell_flags[i].le && (UW'(i) < used_q);
				eq_s2[i] <= cell_flags[i].eq && (UW'(i) < used_q);
			end
		end
		if (valid_s2) begin
			op_s3     <= op_s2;
			val_s3    <= val_s2;
			ok_s3     <= ok_d;
			status_s3 <= status_d;
			at_s3     <= at_d;
		end
		if (fire) begin
			ok_q     <= ok_s3;
			status_q <= status_s3;
			where_q  <= ok_s3 ? 4'(at_s3) : '0;
			count_q  <= 5'(used_next);
			full_q   <= CMPW'(used_next) >= cap_eff;
		end
	end

	// Control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_q  <= 5'd16;
			used_q      <= '0;
			busy_q      <= 1'b0;
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			valid_s3    <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				capacity_q <= cfg_wdata;
			end
			used_q   <= used_next;
			valid_s1 <= accept;
			valid_s2 <= valid_s1;
			// hold the last stage until the output register frees up
			valid_s3 <= valid_s2 || (valid_s3 && !fire);
			if (accept) begin
				busy_q <= 1'b1;
			end else if (fire) begin
				busy_q <= 1'b0;
			end
			if (fire) begin
				res_valid_q <= 1'b1;
			end else if (!res_stall) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	assign res_valid = res_valid_q;
	assign ok        = ok_q;
	assign status    = status_q;
	assign where     = where_q;
	assign count     = count_q;
	assign full_res  = full_q;

	`SSA_ASSERT(a_used_bound, used_q <= UW'(DEPTH), "fill count beyond depth")
	`SSA_ASSERT(a_one_in_flight, $onehot0({valid_s1, valid_s2, valid_s3}), "stages overlap")
	`SSA_ASSERT_NEXT(a_used_inc, ins_fire, used_q == $past(used_q) + 1'b1, "count did not grow")
	`SSA_ASSERT(a_ok_status, res_valid_q |-> (ok_q == (status_q == ST_OK)), "ok and status differ")

endmodule

// ----- tb/sorted_shift_array_unit_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted shift array unit testbench
// Drives insert, delete, sorted add and remove requests through the request
// channel under random bursts and result stalls, and checks every result
// against an in-bench array tracker across a range of capacity settings.
// ----------------------------------------------------------------------------
module sorted_shift_array_unit_tb;
	import ssa_pkg::*;

	localparam int          DEPTH       = 16;
	localparam int unsigned QUIET_LIMIT = 2000;

	localparam logic signed [31:0] VAL_MIN = 32'sh8000_0000;
	localparam logic signed [31:0] VAL_MAX = 32'sh7FFF_FFFF;

	typedef struct packed {
		logic       ok;
		status_t    status;
		logic [3:0] where;
		logic [4:0] count;
		logic       full;
	} outcome_t;

	class array_tracker;
		logic signed [31:0] cells [DEPTH];
		int unsigned        fill;
		logic [4:0]         capacity;
		outcome_t           owed [$];
		int unsigned        failures;

		function new();
			fill = 0;
			capacity = 5'd16;
			failures = 0;
		endfunction

		function void set_capacity(logic [4:0] c);
			capacity = c;
		endfunction

		function int unsigned pending();
			return owed.size();
		endfunction

		function void shift_in(int unsigned at, logic signed [31:0] v);
			for (int unsigned i = fill; i > at; i--)
				cells[i] = cells[i - 1];
			cells[at] = v;
			fill++;
		endfunction

		function void shift_out(int unsigned at);
			for (int unsigned i = at; i + 1 < fill; i++)
				cells[i] = cells[i + 1];
			fill--;
		endfunction

		function void note_request(op_t o, logic [4:0] p, logic signed [31:0] v);
			outcome_t    r;
			int unsigned lim;
			int unsigned at;
			bit          hit;
			lim = (capacity > DEPTH) ? DEPTH : capacity;
			r.ok = 1'b0;
			r.status = ST_OK;
			r.where = 4'd0;
			at = 0;
			hit = 1'b0;
			case (o)
				OP_INSERT: begin
					// full is reported ahead of a bad position
					if (fill >= lim) begin
						r.status = ST_FULL;
					end else if (p > fill) begin
						r.status = ST_BAD_POS;
					end else begin
						shift_in(p, v);
						r.ok = 1'b1;
						r.where = p[3:0];
					end
				end
				OP_DELETE: begin
					if (p >= fill) begin
						r.status = ST_BAD_POS;
					end else begin
						shift_out(p);
						r.ok = 1'b1;
						r.where = p[3:0];
					end
				end
				OP_SORTED: begin
					if (fill >= lim) begin
						r.status = ST_FULL;
					end else begin
						// land after the last entry not above the value, sorted or not
						for (int unsigned i = 0; i < fill; i++)
							if (cells[i] <= v)
								at = i + 1;
						shift_in(at, v);
						r.ok = 1'b1;
						r.where = at[3:0];
					end
				end
				default: begin
					for (int unsigned i = 0; i < fill; i++)
						if (!hit && cells[i] == v) begin
							hit = 1'b1;
							at = i;
						end
					if (!hit) begin
						r.status = ST_NOT_FOUND;
					end else begin
						shift_out(at);
						r.ok = 1'b1;
						r.where = at[3:0];
					end
				end
			endcase
			r.count = fill[4:0];
			r.full = (fill >= lim);
			owed.push_back(r);
		endfunction

		function void check_result(logic ok_o, logic [1:0] st_o, logic [3:0] w_o,
				logic [4:0] c_o, logic f_o);
			outcome_t e;
			if (owed.size() == 0) begin
				$error("result with no request outstanding");
				failures++;
				return;
			end
			e = owed.pop_front();
			if (ok_o !== e.ok) begin
				$error("ok: expected %0d, got %0d", e.ok, ok_o);
				failures++;
			end
			if (st_o !== e.status) begin
				$error("status: expected %0d, got %0d", e.status, st_o);
				failures++;
			end
			if (w_o !== e.where) begin
				$error("where: expected %0d, got %0d", e.where, w_o);
				failures++;
			end
			if (c_o !== e.count) begin
				$error("count: expected %0d, got %0d", e.count, c_o);
				failures++;
			end
			if (f_o !== e.full) begin
				$error("full_res: expected %0d, got %0d", e.full, f_o);
				failures++;
			end
		endfunction
	endclass

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               cfg_we = 1'b0;
	logic [4:0]         cfg_wdata = 5'd0;
	logic               req_valid = 1'b0;
	logic               req_stall;
	op_t                op = OP_INSERT;
	logic [4:0]         position = 5'd0;
	logic signed [31:0] value = 32'sd0;
	logic               res_valid;
	logic               res_stall = 1'b0;
	logic               ok;
	logic [1:0]         status;
	logic [3:0]         where;
	logic [4:0]         count;
	logic               full_res;

	array_tracker tracker = new();

	int unsigned burst_left = 0;
	bit          sender_idles = 1'b1;
	int unsigned stall_mode = 0;
	int unsigned stall_run = 0;
	int unsigned quiet_cycles = 0;

	sorted_shift_array_unit #(.DEPTH(DEPTH)) uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.op        (op),
		.position  (position),
		.value     (value),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.ok        (ok),
		.status    (status),
		.where     (where),
		.count     (count),
		.full_res  (full_res)
	);

	always #6 clk = ~clk;

	// result stalls: none, independently random cycles, or runs of random length
	always @(posedge clk) begin
		if (stall_run != 0) begin
			stall_run <= stall_run - 1;
			res_stall <= 1'b1;
		end else begin
			case (stall_mode)
				1: res_stall <= ($urandom_range(0, 3) == 0);
				2: begin
					if ($urandom_range(0, 5) == 0) begin
						stall_run <= $urandom_range(0, 7);
						res_stall <= 1'b1;
					end else begin
						res_stall <= 1'b0;
					end
				end
				default: res_stall <= 1'b0;
			endcase
		end
	end

	always @(posedge clk) begin
		if (arst_n && res_valid && !res_stall)
			tracker.check_result(ok, status, where, count, full_res);
	end

	always @(posedge clk) begin
		if ((req_valid && !req_stall) || (res_valid && !res_stall))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	task automatic send_request(input op_t o, input logic [4:0] p, input logic signed [31:0] v);
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 20);
			if (sender_idles) begin
				req_valid <= 1'b0;
				repeat ($urandom_range(1, 5)) @(posedge clk);
			end
		end
		req_valid <= 1'b1;
		op <= o;
		position <= p;
		value <= v;
		@(posedge clk);
		while (req_stall) @(posedge clk);
		tracker.note_request(o, p, v);
		burst_left--;
	endtask

	// hold requests until every outstanding result is back
	task automatic drain_results();
		req_valid <= 1'b0;
		burst_left = 0;
		while (tracker.pending() != 0) @(posedge clk);
	endtask

	task automatic write_capacity(input logic [4:0] c);
		cfg_we <= 1'b1;
		cfg_wdata <= c;
		@(posedge clk);
		cfg_we <= 1'b0;
		tracker.set_capacity(c);
	endtask

	function automatic logic signed [31:0] pick_value();
		case ($urandom_range(0, 9))
			0, 1, 2, 3, 4: return $signed(32'($urandom_range(0, 8))) - 32'sd4;
			5: return $urandom_range(0, 1) ? VAL_MIN : VAL_MAX;
			6, 7: begin
				if (tracker.fill != 0)
					return tracker.cells[$urandom_range(0, tracker.fill - 1)];
			end
			default: ;
		endcase
		return $urandom();
	endfunction

	task automatic random_request(input bit grow);
		op_t                o;
		logic [4:0]         p;
		logic signed [31:0] v;
		int unsigned        roll;
		roll = $urandom_range(0, 99);
		if (roll < (grow ? 35 : 15))
			o = OP_INSERT;
		else if (roll < (grow ? 70 : 30))
			o = OP_SORTED;
		else if (roll < (grow ? 85 : 65))
			o = OP_DELETE;
		else
			o = OP_REMOVE;
		if ($urandom_range(0, 9) == 0)
			p = 5'($urandom);
		else if (o == OP_DELETE)
			p = 5'($urandom_range(0, (tracker.fill == 0) ? 0 : tracker.fill - 1));
		else
			p = 5'($urandom_range(0, tracker.fill));
		v = pick_value();
		send_request(o, p, v);
	endtask

	initial begin
		int unsigned caps [10];
		int unsigned pause_at;
		bit          grow;
		caps = '{16, 31, 1, 0, 7, 0, 2, 16, 20, 12};
		caps[5] = $urandom_range(0, 31);
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty array, then a mixed and unsorted fill
		send_request(OP_REMOVE, 5'd0, 32'sd5);
		send_request(OP_DELETE, 5'd0, 32'sd0);
		send_request(OP_INSERT, 5'd1, 32'sd9);
		send_request(OP_INSERT, 5'd0, VAL_MAX);
		send_request(OP_SORTED, 5'd31, VAL_MIN);
		send_request(OP_SORTED, 5'd0, 32'sd0);
		send_request(OP_SORTED, 5'd0, 32'sd0);
		send_request(OP_INSERT, 5'd4, -32'sd1);
		send_request(OP_SORTED, 5'd0, -32'sd1);
		send_request(OP_REMOVE, 5'd0, 32'sd0);
		send_request(OP_DELETE, 5'd31, 32'sd0);
		send_request(OP_INSERT, 5'd31, 32'sd3);
		send_request(OP_DELETE, 5'd5, 32'sd0);
		send_request(OP_DELETE, 5'd4, 32'sd0);
		send_request(OP_REMOVE, 5'd2, 32'sd12345);
		drain_results();

		// capacity below the fill level
		write_capacity(5'd2);
		send_request(OP_INSERT, 5'd31, 32'sd1);
		send_request(OP_SORTED, 5'd0, 32'sd7);
		send_request(OP_DELETE, 5'd0, 32'sd0);
		send_request(OP_REMOVE, 5'd0, VAL_MAX);
		drain_results();

		// zero capacity refuses every insert
		write_capacity(5'd0);
		send_request(OP_INSERT, 5'd0, 32'sd1);
		send_request(OP_SORTED, 5'd0, 32'sd1);
		send_request(OP_REMOVE, 5'd0, -32'sd1);
		send_request(OP_DELETE, 5'd0, 32'sd0);
		drain_results();

		foreach (caps[k]) begin
			write_capacity(caps[k][4:0]);
			stall_mode = k % 3;
			sender_idles = (k % 4 != 1);
			pause_at = $urandom_range(20, 90);
			grow = 1'b1;
			for (int n = 0; n < 105; n++) begin
				if (n != 0 && n % 25 == 0)
					grow = $urandom_range(0, 1);
				if (n == pause_at)
					drain_results();
				random_request(grow);
			end
			drain_results();
		end

		repeat (8) @(posedge clk);
		if (tracker.failures == 0 && tracker.pending() == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule

// ----- sorted_shift_array_unit.f -----
+incdir+hw/rtl
hw/rtl/ssa_pkg.sv
hw/rtl/ssa_cell.sv
hw/rtl/sorted_shift_array_unit.sv
tb/sorted_shift_array_unit_tb.sv
